[hw/rtl/tmqos_pkg.sv]
package tmqos_pkg;

    localparam int OP_W     = 2;
    localparam int TIME_W   = 63;
    localparam int BYTES_W  = 24;
    localparam int STAMP_W  = 64;
    localparam int GAP_W    = 24;
    localparam int WIN_W    = 24;
    localparam int THR_W    = 16;
    localparam int HOLD_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IX_W = 2;
    localparam int TSUM_W   = 25;
    localparam int BSUM_W   = 48;
    localparam int TP_W     = 16;
    localparam int QUOT_W   = 17;
    localparam int DVD_W    = QUOT_W + TSUM_W;
    localparam int MUL_W    = 20;
    localparam int PROD_W   = QUOT_W + MUL_W;
    localparam int MB_SHIFT = 20;

    localparam logic [MUL_W-1:0]  US_PER_S = MUL_W'(1000000);
    localparam logic [QUOT_W-1:0] QUOT_SAT = QUOT_W'(68720);

    localparam logic [GAP_W-1:0]  GAP_LIMIT_RST = GAP_W'(500000);
    localparam logic [WIN_W-1:0]  WINDOW_RST    = WIN_W'(1000000);
    localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(60);
    localparam logic [HOLD_W-1:0] HOLD_RST      = HOLD_W'(2000000);

    localparam logic [CFG_IX_W-1:0] CFG_GAP_LIMIT = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_WINDOW    = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [CFG_IX_W-1:0] CFG_HOLD      = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_XFER  = 2'd0,
        OP_TICK  = 2'd1,
        OP_OPEN  = 2'd2,
        OP_CLOSE = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [TIME_W-1:0]  time_us;
        logic [BYTES_W-1:0] transfer_bytes;
    } item_t;

    typedef struct packed {
        logic            window_done;
        logic [TP_W-1:0] throughput_mbps;
        logic            lock_now;
        logic            unlock_now;
        logic            perf_mode;
        logic            hold_armed;
    } result_t;

endpackage

[hw/rtl/tmqos_div.sv]
module tmqos_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [tmqos_pkg::DVD_W-1:0]      dividend,
    input  logic [tmqos_pkg::TSUM_W-1:0]     divisor,
    output logic [tmqos_pkg::QUOT_W-1:0]     quotient,
    output logic                             done
);

    localparam int CNT_W = $clog2(tmqos_pkg::QUOT_W);

    logic [tmqos_pkg::TSUM_W-1:0] rem_reg, rem_next;
    logic [tmqos_pkg::TSUM_W-1:0] dvsr_reg, dvsr_next;
    logic [tmqos_pkg::QUOT_W-1:0] dq_reg, dq_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    logic [tmqos_pkg::TSUM_W:0]   rem_shift;
    logic [tmqos_pkg::TSUM_W:0]   rem_sub;
    logic                         fits;

    assign rem_shift = {rem_reg, dq_reg[tmqos_pkg::QUOT_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvsr_reg};
    assign fits      = rem_shift >= {1'b0, dvsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        dq_next   = dq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[tmqos_pkg::DVD_W-1:tmqos_pkg::QUOT_W];
            dq_next   = dividend[tmqos_pkg::QUOT_W-1:0];
            dvsr_next = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[tmqos_pkg::TSUM_W-1:0]
                            : rem_shift[tmqos_pkg::TSUM_W-1:0];
            dq_next  = {dq_reg[tmqos_pkg::QUOT_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(tmqos_pkg::QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        dq_reg   <= dq_next;
    end

    assign quotient = dq_reg;
    assign done     = done_reg;

endmodule

[hw/rtl/throughput_monitor_qos_lock_unit.sv]
// channel   direction  handshake                 payload
// item      in         item_valid / item_ready   item   (op, time_us, transfer_bytes)
// result    out        result_valid / result_ready result (one transaction per item)
// cfg       in         cfg_we                    cfg_index, cfg_data
//
// A close, an open or a tick passes through CHECK and FINISH; a transfer passes
// through CHECK, GAP and, unless the gap is too long, SUM, and when it closes a
// window also DIV, SCALE and LOCK (LOCK straight after SUM when the quotient is
// out of range), before FINISH; the bit-serial divider makes one quotient bit per cycle.
// A new item is accepted once the previous one has its result registered.
// A stalled result holds in the output register; a finished item waits for it.
// Reset is asynchronous, active low, and restores the register defaults.
module throughput_monitor_qos_lock_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  tmqos_pkg::item_t                   item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output tmqos_pkg::result_t                 result,
    input  logic                               cfg_we,
    input  logic [tmqos_pkg::CFG_IX_W-1:0]     cfg_index,
    input  logic [tmqos_pkg::CFG_W-1:0]        cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CHECK  = 8'b0000_0010,
        ST_GAP    = 8'b0000_0100,
        ST_SUM    = 8'b0000_1000,
        ST_DIV    = 8'b0001_0000,
        ST_SCALE  = 8'b0010_0000,
        ST_LOCK   = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    tmqos_pkg::op_t                    op_reg;
    logic [tmqos_pkg::TIME_W-1:0]      now_reg;
    logic [tmqos_pkg::BYTES_W-1:0]     bytes_reg;

    logic [tmqos_pkg::TIME_W-1:0]      last_stamp_reg, last_stamp_next;
    logic [tmqos_pkg::TSUM_W-1:0]      time_sum_reg, time_sum_next;
    logic [tmqos_pkg::BSUM_W-1:0]      byte_sum_reg, byte_sum_next;
    logic                              armed_reg, armed_next;
    logic [tmqos_pkg::STAMP_W-1:0]     deadline_reg, deadline_next;
    logic                              mode_reg, mode_next;

    logic                              done_reg, done_next;
    logic [tmqos_pkg::TP_W-1:0]        tp_reg, tp_next;
    logic                              lock_reg, lock_next;
    logic                              unlock_reg, unlock_next;

    tmqos_pkg::result_t                result_reg, result_next;
    logic                              result_valid_reg, result_valid_next;

    logic [tmqos_pkg::GAP_W-1:0]       gap_limit_reg;
    logic [tmqos_pkg::WIN_W-1:0]       window_reg;
    logic [tmqos_pkg::THR_W-1:0]       threshold_reg;
    logic [tmqos_pkg::HOLD_W-1:0]      hold_reg;

    logic [tmqos_pkg::STAMP_W-1:0]     now_ext;
    logic                              deadline_hit;
    logic [tmqos_pkg::STAMP_W-1:0]     delta;
    logic                              gap_ok;
    logic [tmqos_pkg::BSUM_W:0]        bsum_add;
    logic                              win_over;
    logic                              q_big;
    logic [tmqos_pkg::STAMP_W-1:0]     deadline_new;

    logic                              div_start;
    logic [tmqos_pkg::QUOT_W-1:0]      quotient;
    logic                              div_done;
    logic [tmqos_pkg::PROD_W-1:0]      prod;
    logic [tmqos_pkg::TP_W-1:0]        scaled;

    assign now_ext      = {1'b0, now_reg};
    assign deadline_hit = armed_reg && (now_ext >= deadline_reg);
    assign delta        = now_ext - {1'b0, last_stamp_reg};
    assign gap_ok       = delta <= tmqos_pkg::STAMP_W'(gap_limit_reg);
    assign bsum_add     = {1'b0, byte_sum_reg} + (tmqos_pkg::BSUM_W + 1)'(bytes_reg);
    assign win_over     = time_sum_reg > tmqos_pkg::TSUM_W'(window_reg);
    assign q_big        = byte_sum_reg >=
                          tmqos_pkg::BSUM_W'({time_sum_reg, {tmqos_pkg::QUOT_W{1'b0}}});
    assign deadline_new = now_ext + tmqos_pkg::STAMP_W'(hold_reg);

    assign prod   = tmqos_pkg::PROD_W'(quotient) * tmqos_pkg::PROD_W'(tmqos_pkg::US_PER_S);
    assign scaled = (quotient >= tmqos_pkg::QUOT_SAT) ? '1
                  : prod[tmqos_pkg::MB_SHIFT+tmqos_pkg::TP_W-1:tmqos_pkg::MB_SHIFT];

    assign div_start = (state_reg == ST_SUM) && win_over && !q_big;

    tmqos_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (byte_sum_reg[tmqos_pkg::DVD_W-1:0]),
        .divisor  (time_sum_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        last_stamp_next   = last_stamp_reg;
        time_sum_next     = time_sum_reg;
        byte_sum_next     = byte_sum_reg;
        armed_next        = armed_reg;
        deadline_next     = deadline_reg;
        mode_next         = mode_reg;
        done_next         = done_reg;
        tp_next           = tp_reg;
        lock_next         = lock_reg;
        unlock_next       = unlock_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    done_next   = 1'b0;
                    tp_next     = '0;
                    lock_next   = 1'b0;
                    unlock_next = 1'b0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_FINISH;
                unique case (op_reg)
                    tmqos_pkg::OP_XFER,
                    tmqos_pkg::OP_TICK:
                    begin
                        if (deadline_hit)
                        begin
                            armed_next  = 1'b0;
                            mode_next   = 1'b0;
                            unlock_next = 1'b1;
                        end
                        if (op_reg == tmqos_pkg::OP_XFER)
                        begin
                            state_next = ST_GAP;
                        end
                    end
                    tmqos_pkg::OP_OPEN:
                    begin
                        time_sum_next   = '0;
                        byte_sum_next   = '0;
                        last_stamp_next = '0;
                    end
                    tmqos_pkg::OP_CLOSE:
                    begin
                        armed_next = 1'b0;
                    end
                endcase
            end
            ST_GAP:
            begin
                last_stamp_next = now_reg;
                if (gap_ok)
                begin
                    time_sum_next = time_sum_reg
                                  + tmqos_pkg::TSUM_W'(delta[tmqos_pkg::GAP_W-1:0]);
                    byte_sum_next = bsum_add[tmqos_pkg::BSUM_W] ? '1
                                  : bsum_add[tmqos_pkg::BSUM_W-1:0];
                    state_next    = ST_SUM;
                end
                else
                begin
                    time_sum_next = '0;
                    byte_sum_next = '0;
                    state_next    = ST_FINISH;
                end
            end
            ST_SUM:
            begin
                if (win_over)
                begin
                    done_next = 1'b1;
                    if (q_big)
                    begin
                        tp_next    = '1;
                        state_next = ST_LOCK;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                tp_next    = scaled;
                state_next = ST_LOCK;
            end
            ST_LOCK:
            begin
                if (tp_reg >= threshold_reg)
                begin
                    deadline_next = deadline_new;
                    if (!armed_reg)
                    begin
                        armed_next = 1'b1;
                        mode_next  = 1'b1;
                        lock_next  = 1'b1;
                    end
                end
                time_sum_next = '0;
                byte_sum_next = '0;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.window_done     = done_reg;
                    result_next.throughput_mbps = tp_reg;
                    result_next.lock_now        = lock_reg;
                    result_next.unlock_now      = unlock_reg;
                    result_next.perf_mode       = mode_reg;
                    result_next.hold_armed      = armed_reg;
                    result_valid_next           = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            last_stamp_reg   <= '0;
            time_sum_reg     <= '0;
            byte_sum_reg     <= '0;
            armed_reg        <= 1'b0;
            deadline_reg     <= '0;
            mode_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            last_stamp_reg   <= last_stamp_next;
            time_sum_reg     <= time_sum_next;
            byte_sum_reg     <= byte_sum_next;
            armed_reg        <= armed_next;
            deadline_reg     <= deadline_next;
            mode_reg         <= mode_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        done_reg   <= done_next;
        tp_reg     <= tp_next;
        lock_reg   <= lock_next;
        unlock_reg <= unlock_next;
        result_reg <= result_next;
        if (item_valid && item_ready)
        begin
            op_reg    <= item.op;
            now_reg   <= item.time_us;
            bytes_reg <= item.transfer_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg <= tmqos_pkg::GAP_LIMIT_RST;
            window_reg    <= tmqos_pkg::WINDOW_RST;
            threshold_reg <= tmqos_pkg::THRESHOLD_RST;
            hold_reg      <= tmqos_pkg::HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tmqos_pkg::CFG_GAP_LIMIT: gap_limit_reg <= cfg_data[tmqos_pkg::GAP_W-1:0];
                tmqos_pkg::CFG_WINDOW:    window_reg    <= cfg_data[tmqos_pkg::WIN_W-1:0];
                tmqos_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[tmqos_pkg::THR_W-1:0];
                tmqos_pkg::CFG_HOLD:      hold_reg      <= cfg_data[tmqos_pkg::HOLD_W-1:0];
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
